[design/fpsa_pkg.sv]
`default_nettype none

package fpsa_pkg;

    localparam int MAX_TILE_WIDTH_DEF  = 256;
    localparam int MAX_TILE_HEIGHT_DEF = 4096;

    localparam int VALUE_W     = 18;
    localparam int COL_W       = 9;
    localparam int ROW_W       = 13;
    localparam int CFG_W       = 13;
    localparam int SUM_W       = 21;
    localparam int TERM_N      = 4;
    localparam int FIFTH_W     = 14;
    localparam int PROD_W      = SUM_W + FIFTH_W;
    localparam int FIFTH_NUM   = 13107;
    localparam int FIFTH_SHIFT = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = VALUE_W + COL_W + ROW_W;

    typedef enum logic {
        REG_TILE_WIDTH  = 1'b0,
        REG_TILE_HEIGHT = 1'b1
    } fpsa_reg_t;

    // One slot of the accumulate chain: running sum plus the taps still to add.
    typedef struct packed {
        logic                             emit;
        logic                             last;
        logic [COL_W-1:0]                 col;
        logic [ROW_W-1:0]                 row;
        logic [SUM_W-1:0]                 sum;
        logic [TERM_N-1:0][VALUE_W-1:0]   terms;
    } fpsa_cell_t;

endpackage

`default_nettype wire

[design/five_point_stencil_average_unit.sv]
`default_nettype none

// Five-point Jacobi stencil over a padded tile streamed in raster order,
// (tile_width+2) x (tile_height+2) cells. When the cell below an interior cell
// arrives, that cell's new value (sum of centre and four neighbors times
// 13107/65536, truncated) comes out with its interior column and row; tlast
// marks the final interior cell. One cell is accepted every clock; the rate
// is set by the two line buffers, each with one write and two read ports per
// clock. A result follows the cell that completes it through the buffer read,
// four accumulate cells, multiply and output register. When the output is
// held, the whole pipeline holds and s_tready drops. tuser marks a tile start
// and clears the position counters; a register write clears them too.
module five_point_stencil_average_unit
    import fpsa_pkg::*;
#(
    parameter int MAX_TILE_WIDTH  = MAX_TILE_WIDTH_DEF,
    parameter int MAX_TILE_HEIGHT = MAX_TILE_HEIGHT_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // cell_value[17:0], zero pad
    input  wire logic                   s_tuser,   // tile_start
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // new_value, out_column, out_row
    output logic                        m_tlast,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int LINE_DEPTH = MAX_TILE_WIDTH + 2;
    localparam int CW         = $clog2(LINE_DEPTH);
    localparam int RW         = $clog2(MAX_TILE_HEIGHT + 2);

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;

    logic [CW-1:0]    w_eff;
    logic [CW-1:0]    w_last;
    logic [RW-1:0]    h_eff;
    logic [RW-1:0]    h_last;
    logic [CW-1:0]    col_eff;
    logic [RW-1:0]    row_eff;
    logic [CW-1:0]    addr_r;
    logic [CW-1:0]    addr_l;
    logic [VALUE_W-1:0] cur;
    logic             advance;
    logic             accept;
    logic             emit;

    // read-stage registers
    logic             s1_item_reg;
    logic             s1_emit_reg;
    logic             s1_byp_c_reg;
    logic             s1_byp_l_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [VALUE_W-1:0] s1_cur_reg;
    logic [CW-1:0]    s1_waddr_reg;
    logic [VALUE_W-1:0] s1_byp_data_reg;

    logic [VALUE_W-1:0] a_c;
    logic [VALUE_W-1:0] a_r;
    logic [VALUE_W-1:0] b_c_raw;
    logic [VALUE_W-1:0] b_l_raw;

    fpsa_cell_t       chain [TERM_N+1];

    logic             mul_emit_reg;
    logic             mul_last_reg;
    logic [COL_W-1:0] mul_col_reg;
    logic [ROW_W-1:0] mul_row_reg;
    logic [PROD_W-1:0] mul_prod_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign cur      = s_tdata[VALUE_W-1:0];

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_TILE_WIDTH))
        begin
            w_eff = CW'(MAX_TILE_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (32'(height_reg) > 32'(MAX_TILE_HEIGHT))
        begin
            h_eff = RW'(MAX_TILE_HEIGHT);
        end
        else
        begin
            h_eff = RW'(height_reg);
        end
    end

    assign w_last = w_eff + CW'(1);
    assign h_last = h_eff + RW'(1);

    always_comb
    begin
        col_eff = (s_tuser || col_reg > w_last) ? '0 : col_reg;
        row_eff = (s_tuser || row_reg > h_last) ? '0 : row_reg;
        // right tap beyond the last column is never used
        addr_r  = (col_eff > w_eff) ? '0 : col_eff + CW'(1);
        addr_l  = (col_eff == '0) ? '0 : col_eff - CW'(1);
        emit    = (row_eff >= RW'(2)) && (col_eff != '0) && (col_eff <= w_eff);

        if (col_eff >= w_last)
        begin
            col_next = '0;
            row_next = (row_eff >= h_last) ? '0 : row_eff + RW'(1);
        end
        else
        begin
            col_next = col_eff + CW'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COL_W'(128);
            height_reg <= ROW_W'(128);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TILE_WIDTH)
            begin
                width_reg <= cfg_data[COL_W-1:0];
            end
            else
            begin
                height_reg <= cfg_data;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // row above: written with the incoming cell, read at c and c+1
    fpsa_line_buffer #(
        .DEPTH (LINE_DEPTH),
        .AW    (CW),
        .DW    (VALUE_W)
    ) u_row_above (
        .clk    (clk),
        .we     (accept),
        .waddr  (col_eff),
        .wdata  (cur),
        .re     (advance),
        .raddr0 (col_eff),
        .raddr1 (addr_r),
        .rdata0 (a_c),
        .rdata1 (a_r)
    );

    // row two above: gets the old row-above word one stage later, read at c and c-1
    fpsa_line_buffer #(
        .DEPTH (LINE_DEPTH),
        .AW    (CW),
        .DW    (VALUE_W)
    ) u_row_two_above (
        .clk    (clk),
        .we     (advance && s1_item_reg),
        .waddr  (s1_waddr_reg),
        .wdata  (a_c),
        .re     (advance),
        .raddr0 (col_eff),
        .raddr1 (addr_l),
        .rdata0 (b_c_raw),
        .rdata1 (b_l_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg  <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_byp_c_reg <= 1'b0;
            s1_byp_l_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_item_reg  <= accept;
            s1_emit_reg  <= accept && emit;
            // the delayed write lands on this edge, so the RAM read misses it
            s1_byp_c_reg <= accept && s1_item_reg && (col_eff == s1_waddr_reg);
            s1_byp_l_reg <= accept && s1_item_reg && (col_eff != '0)
                            && (addr_l == s1_waddr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg     <= (row_eff == h_last) && (col_eff == w_eff);
            s1_col_reg      <= COL_W'(col_eff);
            s1_row_reg      <= ROW_W'(row_eff - RW'(1));
            s1_cur_reg      <= cur;
            s1_waddr_reg    <= col_eff;
            s1_byp_data_reg <= a_c;
        end
    end

    always_comb
    begin
        chain[0].emit     = s1_emit_reg;
        chain[0].last     = s1_last_reg;
        chain[0].col      = s1_col_reg;
        chain[0].row      = s1_row_reg;
        chain[0].sum      = SUM_W'(s1_cur_reg);
        chain[0].terms[0] = s1_byp_c_reg ? s1_byp_data_reg : b_c_raw;
        chain[0].terms[1] = s1_byp_l_reg ? s1_byp_data_reg : b_l_raw;
        chain[0].terms[2] = a_c;
        chain[0].terms[3] = a_r;
    end

    for (genvar g = 0; g < TERM_N; g++)
    begin : g_cell
        fpsa_sum_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_emit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_emit_reg  <= chain[TERM_N].emit;
            out_valid_reg <= mul_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul_last_reg  <= chain[TERM_N].last;
            mul_col_reg   <= chain[TERM_N].col;
            mul_row_reg   <= chain[TERM_N].row;
            mul_prod_reg  <= PROD_W'(chain[TERM_N].sum) * PROD_W'(FIFTH_NUM);
            out_last_reg  <= mul_last_reg;
            out_col_reg   <= mul_col_reg;
            out_row_reg   <= mul_row_reg;
            out_value_reg <= mul_prod_reg[FIFTH_SHIFT +: VALUE_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_value_reg};

    // both bypasses would mean c and c-1 hit the same pending write
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_byp_c_reg, s1_byp_l_reg}))
        else $error("two-above bypass selected for both taps");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> s1_item_reg)
        else $error("result scheduled without an accepted cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_col_reg != '0) && (out_row_reg != '0))
        else $error("result on a padding position");

endmodule

`default_nettype wire

[design/fpsa_line_buffer.sv]
`default_nettype none

module fpsa_line_buffer #(
    parameter int DEPTH = 258,
    parameter int AW    = 9,
    parameter int DW    = 18
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr0,
    input  wire logic [AW-1:0] raddr1,
    output logic      [DW-1:0] rdata0,
    output logic      [DW-1:0] rdata1
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata0_reg;
    logic [DW-1:0] rdata1_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

[design/fpsa_sum_cell.sv]
`default_nettype none

module fpsa_sum_cell
    import fpsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire fpsa_cell_t cell_in,
    output fpsa_cell_t      cell_out
);

    fpsa_cell_t cell_reg;
    fpsa_cell_t cell_next;

    // add the front tap, shift the rest toward the front
    always_comb
    begin
        cell_next     = cell_in;
        cell_next.sum = cell_in.sum + SUM_W'(cell_in.terms[0]);
        for (int i = 0; i < TERM_N - 1; i++)
        begin
            cell_next.terms[i] = cell_in.terms[i+1];
        end
        cell_next.terms[TERM_N-1] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

[sim/stencil_result_checker.sv]
module stencil_result_checker
    import fpsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // cell_value[17:0], zero pad
    input  logic                   s_tuser,   // tile_start
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // new_value, out_column, out_row
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     pending,
    output int                     mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W         = MAX_TILE_WIDTH_DEF;
    localparam int unsigned MAX_H         = MAX_TILE_HEIGHT_DEF;
    localparam int unsigned ONE_FIFTH_Q16 = 13107;
    localparam int unsigned Q_FRAC        = 16;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] new_value;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic               last;
    } stencil_cell_t;

    logic [VALUE_W-1:0] row_above     [0:MAX_W+1];
    logic [VALUE_W-1:0] row_two_above [0:MAX_W+1];
    logic [COL_W-1:0]   width_reg;
    logic [ROW_W-1:0]   height_reg;
    int unsigned        col_pos;
    int unsigned        row_pos;
    stencil_cell_t      expected_cells [$];

    // Advance the tile position by one cell and queue the updated interior
    // value once the cell below it has arrived.
    task automatic stencil_step(input logic [VALUE_W-1:0] cur, input logic start);
        int unsigned      eff_w;
        int unsigned      eff_h;
        int unsigned      c;
        int unsigned      r;
        logic [SUM_W-1:0] sum;
        logic [34:0]      prod;
        stencil_cell_t    res;
        eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        eff_h = (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : height_reg);
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos > eff_w + 1)
            col_pos = 0;
        if (row_pos > eff_h + 1)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        if (r >= 2 && c >= 1 && c <= eff_w)
        begin
            // two_above[c-1] was already shifted this row, so it is the left neighbor
            sum = row_two_above[c] + row_two_above[c-1] + row_above[c] + row_above[c+1] + cur;
            prod = sum * ONE_FIFTH_Q16;
            res.new_value = prod[Q_FRAC +: VALUE_W];
            res.column    = COL_W'(c);
            res.row       = ROW_W'(r - 1);
            res.last      = (r == eff_h + 1) && (c == eff_w);
            expected_cells.push_back(res);
        end
        row_two_above[c] = row_above[c];
        row_above[c]     = cur;
        if (c >= eff_w + 1)
        begin
            col_pos = 0;
            row_pos = (r >= eff_h + 1) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    always @(posedge clk)
    begin : watch
        stencil_cell_t got;
        stencil_cell_t want;
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_W + 1; i++)
            begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            width_reg  = COL_W'(128);
            height_reg = ROW_W'(128);
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            expected_cells.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TILE_WIDTH)
                    width_reg = cfg_data[COL_W-1:0];
                else
                    height_reg = cfg_data[ROW_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            if (s_tvalid && s_tready)
                stencil_step(s_tdata[VALUE_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
            begin
                got.new_value = m_tdata[VALUE_W-1:0];
                got.column    = m_tdata[VALUE_W +: COL_W];
                got.row       = m_tdata[VALUE_W+COL_W +: ROW_W];
                got.last      = m_tlast;
                if (expected_cells.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: value %0d column %0d row %0d last %0b",
                                 got.new_value, got.column, got.row, got.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (got.new_value !== want.new_value || got.column !== want.column ||
                        got.row !== want.row || got.last !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $write("result mismatch: expected %0d col %0d row %0d last %0b",
                                   want.new_value, want.column, want.row, want.last);
                            $display(", got %0d col %0d row %0d last %0b",
                                     got.new_value, got.column, got.row, got.last);
                        end
                        mismatches++;
                    end
                end
            end
        end
        pending = expected_cells.size();
    end

endmodule

[sim/five_point_stencil_average_unit_tb.sv]
module five_point_stencil_average_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpsa_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_CELLS  = 350;
    localparam logic [VALUE_W-1:0] CELL_MAX = '1;

    typedef enum {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int          pending;
    int          mismatches;
    bit          hold_off_req = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned cells_sent   = 0;
    int unsigned tile_w       = 128;
    int unsigned tile_h       = 128;
    int unsigned stall_cycles = 0;

    always #5 clk = ~clk;

    five_point_stencil_average_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stencil_result_checker stencil_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_cell_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CELL_MAX;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    // One request per call; tvalid stays high across back-to-back requests.
    task automatic send_cell(input logic [VALUE_W-1:0] value, input logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(value);
        s_tuser  <= start;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        cells_sent++;
    endtask

    // Cells that produce no result may still be in flight after the last result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_tile_size(input bit write_w, input logic [CFG_W-1:0] w,
                                 input bit write_h, input logic [CFG_W-1:0] h);
        if (write_w)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_TILE_WIDTH;
            cfg_data  <= w;
            tile_w = clamp_dim(w[COL_W-1:0], MAX_TILE_WIDTH_DEF);
            @(negedge clk);
        end
        if (write_h)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_TILE_HEIGHT;
            cfg_data  <= h;
            tile_h = clamp_dim(h[ROW_W-1:0], MAX_TILE_HEIGHT_DEF);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_tile(input bit mark_start);
        int unsigned total;
        total = (tile_w + 2) * (tile_h + 2);
        for (int unsigned i = 0; i < total; i++)
            send_cell(pick_cell_value(), mark_start && (i == 0));
    endtask

    // Cut-off tile; the caller restarts with tile_start.
    task automatic send_broken_tile();
        int unsigned part;
        part = $urandom_range(1, (tile_w + 2) * (tile_h + 2) - 1);
        for (int unsigned i = 0; i < part; i++)
            send_cell(pick_cell_value(), (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
    endtask

    initial
    begin : receiver
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        rx_tick   = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= (rx_tick % 3 != 0);
                    default:     m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned      random_start;
        int unsigned      phase;
        bit               write_w;
        bit               write_h;
        bit               restart;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_TILE_WIDTH;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // 3x2 tile at full scale and zero, after a start that is cut short
        set_tile_size(1'b1, CFG_W'(3), 1'b1, CFG_W'(2));
        send_cell(CELL_MAX, 1'b1);
        send_cell('0, 1'b0);
        send_cell(VALUE_W'(18'h2AAAA), 1'b0);
        send_cell(VALUE_W'(18'h15555), 1'b0);
        for (int i = 0; i < 20; i++)
            send_cell((i % 4 == 1) ? VALUE_W'(0) : CELL_MAX, i == 0);
        settle();

        random_start = cells_sent;
        phase        = 0;
        restart      = 1'b0;
        while (cells_sent - random_start < RANDOM_CELLS)
        begin
            if (phase == 0)
            begin
                set_tile_size(1'b1, CFG_W'(6), 1'b1, CFG_W'(6));
                hold_off_req = 1'b1;
            end
            else
            begin
                write_w = ($urandom_range(0, 3) != 0);
                write_h = !write_w || ($urandom_range(0, 2) != 0);
                new_w = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 16));
                new_h = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 10));
                set_tile_size(write_w, new_w, write_h, new_h);
            end
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_broken_tile();
                    restart = 1'b1;
                end
                // without tile_start the counters must wrap on their own
                send_tile(restart || ($urandom_range(0, 1) == 1));
                restart = 1'b0;
            end
            settle();
            phase++;
        end

        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
